// ----- design/edge_normalized_box_filter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the edge-normalized box filter
// Shared immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef EDGE_NORMALIZED_BOX_FILTER_UNIT_MACROS_SVH
`define EDGE_NORMALIZED_BOX_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define EBF_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define EBF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ebf_pkg.sv -----
// ----------------------------------------------------------------------------
// ebf_pkg
// Types, constants and codes shared by the box filter controller and datapath.
// ----------------------------------------------------------------------------
package ebf_pkg;

   // Parameter defaults
   localparam int MAX_WIDTH_DEFAULT   = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Configuration registers
   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 16;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

   // Growth of a sum of up to nine samples, plus a sign guard
   localparam int SUM_GROWTH = 4;

   // Divider: width of the odd divisor factor (1, 3 or 9)
   localparam int DIV_REM_BITS  = 4;

   // Result selector: which neighbourhood a result is centered on
   localparam logic [1:0] SEL_PREV_ROW_PREV_COL = 2'd0;
   localparam logic [1:0] SEL_PREV_ROW_LAST_COL = 2'd1;
   localparam logic [1:0] SEL_LAST_ROW_PREV_COL = 2'd2;
   localparam logic [1:0] SEL_LAST_ROW_LAST_COL = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_START,
      ST_DIV,
      ST_OUT
   } ebf_state_type;

   typedef struct packed {
      logic       accept;
      logic       win_load;
      logic       acc_en;
      logic       acc_first;
      logic [1:0] sum_col;
      logic       div_start;
      logic       out_load;
      logic [1:0] sel;
      logic       run_last;
      logic       frame_last;
   } ebf_cmd_type;

   typedef struct packed {
      logic [3:0] emit_mask;
      logic       div_busy;
      logic       div_done;
      logic       out_free;
   } ebf_status_type;

endpackage

// ----- design/ebf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ebf_ctrl
// Sequencer: takes one sample, then walks each pending result through
// accumulate, divide and output-register load.
// ----------------------------------------------------------------------------
module ebf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ebf_pkg::ebf_status_type status,
   output ebf_pkg::ebf_cmd_type    cmd
);
   import ebf_pkg::*;

   ebf_state_type state_ff, state_in;
   logic [3:0]    pend_ff, pend_in;
   logic [1:0]    sum_cnt_ff, sum_cnt_in;
   logic [1:0]    sel;
   logic [3:0]    sel_onehot;
   logic [3:0]    pend_rest;

   // Lowest pending result goes first
   always_comb begin
      if (pend_ff[0]) begin
         sel = SEL_PREV_ROW_PREV_COL;
      end else if (pend_ff[1]) begin
         sel = SEL_PREV_ROW_LAST_COL;
      end else if (pend_ff[2]) begin
         sel = SEL_LAST_ROW_PREV_COL;
      end else begin
         sel = SEL_LAST_ROW_LAST_COL;
      end
      sel_onehot = 4'b0001 << sel;
      pend_rest  = pend_ff & ~sel_onehot;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = (status.emit_mask != 4'd0) ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            if (sum_cnt_ff == 2'd2) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = (pend_rest != 4'd0) ? ST_SUM : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      if (state_ff == ST_LOAD) begin
         pend_in = status.emit_mask;
      end else if (state_ff == ST_OUT && status.out_free) begin
         pend_in = pend_rest;
      end
      sum_cnt_in = 2'd0;
      if (state_ff == ST_SUM && sum_cnt_ff != 2'd2) begin
         sum_cnt_in = sum_cnt_ff + 2'd1;
      end
   end

   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.win_load   = (state_ff == ST_LOAD);
      cmd.acc_en     = (state_ff == ST_SUM);
      cmd.acc_first  = (state_ff == ST_SUM) && (sum_cnt_ff == 2'd0);
      cmd.sum_col    = sum_cnt_ff;
      cmd.div_start  = (state_ff == ST_START);
      cmd.out_load   = (state_ff == ST_OUT) && status.out_free;
      cmd.sel        = sel;
      cmd.run_last   = (pend_rest == 4'd0);
      cmd.frame_last = (sel == SEL_LAST_ROW_LAST_COL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= 4'd0;
         sum_cnt_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         sum_cnt_ff <= sum_cnt_in;
      end
   end

endmodule

// ----- design/ebf_div.sv -----
// ----------------------------------------------------------------------------
// ebf_div
// Signed division by a small divisor (2^shift times 1, 3 or 9), truncating
// toward zero; multiply by the divisor's reciprocal, one half per cycle.
// ----------------------------------------------------------------------------
module ebf_div #(
   parameter int SAMPLE_BITS = ebf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [SAMPLE_BITS+ebf_pkg::SUM_GROWTH-1:0] dividend,
   input  logic [1:0]                                shift,
   input  logic [ebf_pkg::DIV_REM_BITS-1:0]          odd,
   output logic                                      busy,
   output logic                                      done,
   output logic [SAMPLE_BITS-1:0]                    quotient
);
   import ebf_pkg::*;

   localparam int SUM_BITS    = SAMPLE_BITS + SUM_GROWTH;
   // magnitude of a nine-sample sum stays below 2^(SAMPLE_BITS+3)
   localparam int MAG_BITS    = SAMPLE_BITS + 3;
   // three guard bits keep the rounded-up reciprocal exact for divisors up to 9
   localparam int RECIP_SHIFT = MAG_BITS + 3;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int LO_BITS     = (RECIP_BITS + 1) / 2;
   localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;

   localparam logic [RECIP_BITS-1:0] RECIP_ONE   =
      RECIP_BITS'(longint'(1) << RECIP_SHIFT);
   localparam logic [RECIP_BITS-1:0] RECIP_THREE =
      RECIP_BITS'(((longint'(1) << RECIP_SHIFT) + 2) / 3);
   localparam logic [RECIP_BITS-1:0] RECIP_NINE  =
      RECIP_BITS'(((longint'(1) << RECIP_SHIFT) + 8) / 9);

   logic [MAG_BITS-1:0]   x_ff;
   logic [RECIP_BITS-1:0] recip_ff;
   logic                  neg_ff;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                  hi_phase_ff, hi_phase_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [SUM_BITS-1:0]         mag;
   logic [SUM_BITS-1:0]         shifted;
   logic [RECIP_BITS-1:0]       recip;
   logic [LO_BITS-1:0]          recip_part;
   logic [MAG_BITS+LO_BITS-1:0] part_prod;
   logic [MAG_BITS:0]           q_mag;
   logic [MAG_BITS:0]           signed_q;

   always_comb begin
      mag     = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
      shifted = mag >> shift;
      if (odd == DIV_REM_BITS'(9)) begin
         recip = RECIP_NINE;
      end else if (odd == DIV_REM_BITS'(3)) begin
         recip = RECIP_THREE;
      end else begin
         recip = RECIP_ONE;
      end
   end

   // Low half of the reciprocal first, then the high half on top
   always_comb begin
      recip_part = hi_phase_ff ? LO_BITS'(recip_ff[RECIP_BITS-1:LO_BITS])
                               : recip_ff[LO_BITS-1:0];
      part_prod  = x_ff * recip_part;
   end

   always_comb begin
      prod_in     = prod_ff;
      hi_phase_in = hi_phase_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (start) begin
         hi_phase_in = 1'b0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (!hi_phase_ff) begin
            prod_in     = PROD_BITS'(part_prod);
            hi_phase_in = 1'b1;
         end else begin
            prod_in     = prod_ff + (PROD_BITS'(part_prod) << LO_BITS);
            hi_phase_in = 1'b0;
            busy_in     = 1'b0;
            done_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
         hi_phase_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         hi_phase_ff <= hi_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (start) begin
         x_ff     <= shifted[MAG_BITS-1:0];
         recip_ff <= recip;
         neg_ff   <= dividend[SUM_BITS-1];
      end
   end

   always_comb begin
      q_mag    = prod_ff[PROD_BITS-1:RECIP_SHIFT];
      signed_q = neg_ff ? (~q_mag + 1'b1) : q_mag;
   end

   assign quotient = signed_q[SAMPLE_BITS-1:0];
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

// ----- design/ebf_datapath.sv -----
// ----------------------------------------------------------------------------
// ebf_datapath
// Frame position, line stores, 3x3 window, masked accumulator, divider and
// output register of the box filter.
// ----------------------------------------------------------------------------
module ebf_datapath #(
   parameter int MAX_WIDTH   = ebf_pkg::MAX_WIDTH_DEFAULT,
   parameter int SAMPLE_BITS = ebf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ebf_pkg::ebf_cmd_type                   cmd,
   output ebf_pkg::ebf_status_type                status,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [ebf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ebf_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import ebf_pkg::*;

   localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int ADDR_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WEFF_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int SUM_BITS   = SAMPLE_BITS + SUM_GROWTH;

   // Configuration and position
   logic [FRAME_WIDTH_BITS-1:0]  fw_ff;
   logic [FRAME_HEIGHT_BITS-1:0] fh_ff;
   logic [ADDR_BITS-1:0]         col_ff, col_in;
   logic [FRAME_HEIGHT_BITS-1:0] row_ff, row_in;

   logic [WEFF_BITS-1:0]         w_eff;
   logic [FRAME_HEIGHT_BITS-1:0] h_eff;
   logic [ADDR_BITS-1:0]         c_eff;
   logic [FRAME_HEIGHT_BITS-1:0] r_eff;
   logic                         last_col, last_row;

   // Per-sample flags, held for the duration of its results
   logic                 c_ge1_ff, c_ge2_ff, r_ge1_ff, r_ge2_ff;
   logic                 last_col_ff, last_row_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   // Line stores
   logic signed [SAMPLE_BITS-1:0] older_mem_ff [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] newer_mem_ff [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] older_rd_ff, newer_rd_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;

   // Window: column 2 is the newest, row slot 2 the current row
   logic signed [SAMPLE_BITS-1:0] win_ff [3][3];

   logic [2:0]                 row_mask, col_mask;
   logic [1:0]                 row_cnt, col_cnt;
   logic [1:0]                 div_shift;
   logic [DIV_REM_BITS-1:0]    div_odd;
   logic signed [SUM_BITS-1:0] colsum;
   logic signed [SUM_BITS-1:0] acc_ff, acc_in;

   logic                   div_busy, div_done;
   logic [SAMPLE_BITS-1:0] quotient;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic                   run_last_ff, frame_last_ff;

   // Effective frame size and clamped position
   always_comb begin
      if (fw_ff == '0) begin
         w_eff = WEFF_BITS'(1);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WEFF_BITS'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_BITS'(fw_ff);
      end
      h_eff    = (fh_ff == '0) ? FRAME_HEIGHT_BITS'(1) : fh_ff;
      c_eff    = (32'(col_ff) >= 32'(w_eff)) ? '0 : col_ff;
      r_eff    = (row_ff >= h_eff) ? '0 : row_ff;
      last_col = ((32'(c_eff) + 32'd1) == 32'(w_eff));
      last_row = (r_eff == (h_eff - 1'b1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : (r_eff + 1'b1);
         end else begin
            col_in = ADDR_BITS'(32'(c_eff) + 32'd1);
            row_in = r_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= FRAME_WIDTH_RESET;
         fh_ff  <= FRAME_HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  fw_ff <= csr_wdata[FRAME_WIDTH_BITS-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  fh_ff <= csr_wdata[FRAME_HEIGHT_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Capture the sample and its position flags
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff   <= req_tdata[SAMPLE_BITS-1:0];
         addr_ff     <= c_eff;
         c_ge1_ff    <= (c_eff >= ADDR_BITS'(1));
         c_ge2_ff    <= (32'(c_eff) >= 32'd2);
         r_ge1_ff    <= (r_eff >= FRAME_HEIGHT_BITS'(1));
         r_ge2_ff    <= (r_eff >= FRAME_HEIGHT_BITS'(2));
         last_col_ff <= last_col;
         last_row_ff <= last_row;
      end
   end

   // Line stores: read on accept, write back as the window loads
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         older_rd_ff <= older_mem_ff[c_eff];
         newer_rd_ff <= newer_mem_ff[c_eff];
      end
      if (cmd.win_load) begin
         older_mem_ff[addr_ff] <= newer_rd_ff;
         newer_mem_ff[addr_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_load) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1]    <= win_ff[2];
         win_ff[2][0] <= older_rd_ff;
         win_ff[2][1] <= newer_rd_ff;
         win_ff[2][2] <= sample_ff;
      end
   end

   // Clip masks of the selected neighbourhood and its divisor
   always_comb begin
      case (cmd.sel)
         SEL_PREV_ROW_PREV_COL: begin
            row_mask = {2'b11, r_ge2_ff};
            col_mask = {2'b11, c_ge2_ff};
         end
         SEL_PREV_ROW_LAST_COL: begin
            row_mask = {2'b11, r_ge2_ff};
            col_mask = {1'b1, c_ge1_ff, 1'b0};
         end
         SEL_LAST_ROW_PREV_COL: begin
            row_mask = {1'b1, r_ge1_ff, 1'b0};
            col_mask = {2'b11, c_ge2_ff};
         end
         default: begin
            row_mask = {1'b1, r_ge1_ff, 1'b0};
            col_mask = {1'b1, c_ge1_ff, 1'b0};
         end
      endcase
      row_cnt   = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
      col_cnt   = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);
      div_shift = 2'(row_cnt == 2'd2) + 2'(col_cnt == 2'd2);
      if (row_cnt == 2'd3 && col_cnt == 2'd3) begin
         div_odd = DIV_REM_BITS'(9);
      end else if (row_cnt == 2'd3 || col_cnt == 2'd3) begin
         div_odd = DIV_REM_BITS'(3);
      end else begin
         div_odd = DIV_REM_BITS'(1);
      end
   end

   // One window column per cycle into the accumulator
   always_comb begin
      colsum = '0;
      for (int s = 0; s < 3; s++) begin
         if (row_mask[s] && col_mask[cmd.sum_col]) begin
            colsum = colsum + SUM_BITS'(win_ff[cmd.sum_col][s]);
         end
      end
      acc_in = cmd.acc_first ? colsum : (acc_ff + colsum);
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   ebf_div #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(acc_ff),
      .shift   (div_shift),
      .odd     (div_odd),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(quotient)
   );

   // Output register: hold until taken
   always_comb begin
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mean_ff       <= quotient;
         run_last_ff   <= cmd.run_last;
         frame_last_ff <= cmd.frame_last;
      end
   end

   always_comb begin
      status.emit_mask = {last_row_ff && last_col_ff,
                          last_row_ff && c_ge1_ff,
                          r_ge1_ff && last_col_ff,
                          r_ge1_ff && c_ge1_ff};
      status.div_busy  = div_busy;
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(mean_ff);
   assign rsp_tlast  = run_last_ff;
   assign rsp_tuser  = frame_last_ff;

endmodule

// ----- design/edge_normalized_box_filter_unit.sv -----
// ----------------------------------------------------------------------------
// edge_normalized_box_filter_unit
// 3x3 mean filter over a raster frame, neighbourhood clipped at the borders.
// ----------------------------------------------------------------------------
// Samples enter in raster order; each result is the mean of the clipped 3x3
// neighbourhood, truncated toward zero, and leaves as soon as its last sample
// has arrived, so one sample yields zero to four results (rsp_tlast marks the
// last of them, rsp_tuser the frame's final position). Each sample is loaded
// into the window, then each result it yields goes through the single
// accumulate-and-divide path, which adds one window column per cycle and
// then multiplies by the divisor's reciprocal in two halves; a result may
// wait for the output register to be taken. The last result waits in the
// output register while the next sample is taken. The line stores need no
// clearing after reset. Writing frame_width or frame_height restarts the
// frame at its first position; write them only while the unit is idle.
`include "edge_normalized_box_filter_unit_macros.svh"

module edge_normalized_box_filter_unit #(
   parameter int MAX_WIDTH   = ebf_pkg::MAX_WIDTH_DEFAULT,
   parameter int SAMPLE_BITS = ebf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,  // sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]   rsp_tdata,  // mean_value
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,  // frame_last
   input  logic                               csr_we,
   input  logic [ebf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ebf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ebf_pkg::*;

   ebf_cmd_type    cmd;
   ebf_status_type status;

   ebf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ebf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   `EBF_ASSERT_IMP(a_ready_div_idle, req_tready, !status.div_busy, "sample taken while dividing")
   `EBF_ASSERT_NEXT(a_one_sample, req_tvalid && req_tready, !req_tready, "second sample taken early")
   `EBF_ASSERT_NEXT(a_div_runs, cmd.div_start, status.div_busy, "divider did not start")
   `EBF_ASSERT_IMP(a_frame_end_last, rsp_tvalid && rsp_tuser, rsp_tlast, "frame end not last result")

endmodule
